// ===== hw/rtl/rvsc_pkg.sv =====
// Shared types, constants and opcodes of the RV32 subset core.
package rvsc_pkg;

  localparam int unsigned XLEN          = 32;
  localparam int unsigned REG_FIELD_W   = 5;
  localparam int unsigned REG_NUM_W     = 4;
  localparam int unsigned LOAD_ADDR_W   = 10;
  localparam int unsigned MEM_WORD_W    = 10;
  localparam int unsigned MEM_WORDS_DEF = 1024;
  localparam int unsigned NUM_REGS_DEF  = 16;

  // Request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  // Supported major opcodes
  localparam logic [6:0] OP_ADDI  = 7'h13;
  localparam logic [6:0] OP_JALR  = 7'h67;
  localparam logic [6:0] OP_ADD   = 7'h33;
  localparam logic [6:0] OP_LUI   = 7'h37;
  localparam logic [6:0] OP_LOAD  = 7'h03;
  localparam logic [6:0] OP_STORE = 7'h23;

  // Load and store widths (funct3)
  localparam logic [2:0] F3_WORD = 3'd2;
  localparam logic [2:0] F3_BU   = 3'd4;
  localparam logic [2:0] F3_BYTE = 3'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EXEC,
    ST_MEM
  } ctrl_state_e;

  typedef struct packed {
    logic                   req_type;
    logic [LOAD_ADDR_W-1:0] load_addr;
    logic [XLEN-1:0]        load_data;
  } req_t;

  typedef struct packed {
    logic [XLEN-1:0]       pc_after;
    logic                  reg_we;
    logic [REG_NUM_W-1:0]  reg_num;
    logic [XLEN-1:0]       reg_value;
    logic                  mem_we;
    logic [MEM_WORD_W-1:0] mem_word;
    logic                  bad_opcode;
  } rsp_t;

endpackage

// ===== hw/rtl/rvsc_mem.sv =====
// Unified word memory: one write port, one registered read port, write-first.
module rvsc_mem import rvsc_pkg::*; #(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF,
  localparam int unsigned AW       = $clog2(MEM_WORDS)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  logic [XLEN-1:0] wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output logic [XLEN-1:0] rdata_o
);

  logic [XLEN-1:0] mem_q [MEM_WORDS];
  logic [XLEN-1:0] rdata_q;

  // Write the word; forward it to a read of the same word in the same cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= (we_i && (waddr_i == raddr_i)) ? wdata_i : mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/rvsc_regfile.sv =====
// Register file: two registered read ports, one write port, per-entry valid bits.
module rvsc_regfile import rvsc_pkg::*; #(
  parameter int unsigned NUM_REGS = NUM_REGS_DEF,
  localparam int unsigned RIDX_W  = $clog2(NUM_REGS)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   re_i,
  input  logic [REG_FIELD_W-1:0] raddr1_i,
  input  logic [REG_FIELD_W-1:0] raddr2_i,
  output logic [XLEN-1:0]        rdata1_o,
  output logic [XLEN-1:0]        rdata2_o,
  input  logic                   we_i,
  input  logic [REG_FIELD_W-1:0] waddr_i,
  input  logic [XLEN-1:0]        wdata_i
);

  logic [XLEN-1:0]     regs_q [NUM_REGS];
  logic [NUM_REGS-1:0] vld_q;
  logic [XLEN-1:0]     rd1_q, rd2_q;
  logic                ok1_q, ok2_q;
  logic                in1, in2, inw;

  // An index at or beyond the file size reads as zero and is never written
  assign in1 = {1'b0, raddr1_i} < (REG_FIELD_W + 1)'(NUM_REGS);
  assign in2 = {1'b0, raddr2_i} < (REG_FIELD_W + 1)'(NUM_REGS);
  assign inw = {1'b0, waddr_i}  < (REG_FIELD_W + 1)'(NUM_REGS);

  // Mark entries written since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      ok1_q <= 1'b0;
      ok2_q <= 1'b0;
    end else begin
      if (we_i && inw) begin
        vld_q[waddr_i[RIDX_W-1:0]] <= 1'b1;
      end
      if (re_i) begin
        ok1_q <= in1 && vld_q[raddr1_i[RIDX_W-1:0]];
        ok2_q <= in2 && vld_q[raddr2_i[RIDX_W-1:0]];
      end
    end
  end

  // Storage array and registered reads
  always_ff @(posedge clk_i) begin
    if (we_i && inw) begin
      regs_q[waddr_i[RIDX_W-1:0]] <= wdata_i;
    end
    if (re_i) begin
      rd1_q <= regs_q[raddr1_i[RIDX_W-1:0]];
      rd2_q <= regs_q[raddr2_i[RIDX_W-1:0]];
    end
  end

  assign rdata1_o = ok1_q ? rd1_q : '0;
  assign rdata2_o = ok2_q ? rd2_q : '0;

endmodule

// ===== hw/rtl/rv32_subset_core_step.sv =====
// Top level: request sequencer, execute datapath and result register.
//
// Input channel (in_valid_i / in_stall_o / in_req_i): each request either
// writes one memory word (REQ_WRITE) or executes the instruction at the pc
// (REQ_STEP). Output channel (out_valid_o / out_stall_i / out_rsp_o): exactly
// one result per request, in request order.
// States per request, set by the single memory read port and the registered
// register-file read (fetch, then register read, then data access):
//   memory word write              completes as it is taken, from idle
//   addi, add, lui, jalr, sw,
//   unsupported or ignored opcodes decode, execute
//   lw, lbu, sb                    decode, execute, memory
// The next step request is taken in the cycle the current one completes.
// A result sits in an output register, so the core keeps working while it
// waits to be taken; a request completes only when that register is free or
// being emptied, so a stalled receiver holds the core in its last stage.
// Reset clears pc, the register file valid bits and all control; memory
// contents are undefined until written. MEM_WORDS must be a power of two.
module rv32_subset_core_step import rvsc_pkg::*; #(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF,
  parameter int unsigned NUM_REGS  = NUM_REGS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  ctrl_state_e state_q, state_d;
  logic [XLEN-1:0] pc_q, pc_d;
  logic [XLEN-1:0] inst_q;
  logic            out_valid_q;
  rsp_t            out_rsp_q, rsp_d;

  // Handshake and sequencing
  logic in_acc, step_acc, write_acc, can_emit, idle, fin;

  // Memory and register file ports
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [XLEN-1:0] mem_wdata, mem_rdata;
  logic            rf_re, rf_we;
  logic [XLEN-1:0] rf_rdata1, rf_rdata2;

  // Datapath
  logic [6:0]             op;
  logic [REG_FIELD_W-1:0] rd;
  logic [2:0]             f3;
  logic [XLEN-1:0]        imm_i, imm_s, addr_x, a_plus_i, pc_plus4, pc_next_x;
  logic [XLEN-1:0]        alu_val, ld_val, sb_merged;
  logic [AW-1:0]          widx_x;
  logic [1:0]             lane;
  logic is_lw, is_lbu, is_sw, is_sb, mem_access, alu_wr, bad, rd_ok;
  logic wr_load, wr_sw, wr_sb;

  rvsc_mem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  rvsc_regfile #(
    .NUM_REGS (NUM_REGS)
  ) u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .re_i     (rf_re),
    .raddr1_i (mem_rdata[19:15]),
    .raddr2_i (mem_rdata[24:20]),
    .rdata1_o (rf_rdata1),
    .rdata2_o (rf_rdata2),
    .we_i     (rf_we),
    .waddr_i  (rd),
    .wdata_i  (rsp_d.reg_value)
  );

  // Decode and execute the latched instruction against the register operands
  always_comb begin
    op       = inst_q[6:0];
    rd       = inst_q[11:7];
    f3       = inst_q[14:12];
    imm_i    = {{(XLEN-12){inst_q[31]}}, inst_q[31:20]};
    imm_s    = {{(XLEN-12){inst_q[31]}}, inst_q[31:25], inst_q[11:7]};
    a_plus_i = rf_rdata1 + imm_i;
    addr_x   = (op == OP_STORE) ? (rf_rdata1 + imm_s) : a_plus_i;
    widx_x   = addr_x[AW+1:2];
    lane     = addr_x[1:0];
    pc_plus4 = pc_q + XLEN'(4);
    rd_ok    = (rd != '0) && ({1'b0, rd} < (REG_FIELD_W + 1)'(NUM_REGS));

    is_lw  = (op == OP_LOAD)  && (f3 == F3_WORD);
    is_lbu = (op == OP_LOAD)  && (f3 == F3_BU);
    is_sw  = (op == OP_STORE) && (f3 == F3_WORD);
    is_sb  = (op == OP_STORE) && (f3 == F3_BYTE);
    mem_access = is_lw || is_lbu || is_sb;

    alu_wr    = 1'b1;
    bad       = 1'b0;
    alu_val   = '0;
    pc_next_x = pc_plus4;
    unique case (op)
      OP_ADDI: alu_val = a_plus_i;
      OP_ADD:  alu_val = rf_rdata1 + rf_rdata2;
      OP_LUI:  alu_val = {inst_q[31:12], 12'b0};
      OP_JALR: begin
        alu_val   = pc_plus4;
        pc_next_x = {a_plus_i[XLEN-1:1], 1'b0};
      end
      OP_LOAD, OP_STORE: alu_wr = 1'b0;
      default: begin
        alu_wr = 1'b0;
        bad    = 1'b1;
      end
    endcase

    // Byte lane extract for lbu, byte merge for sb
    ld_val = is_lbu ? {{(XLEN-8){1'b0}}, mem_rdata[{lane, 3'b000} +: 8]} : mem_rdata;
    for (int i = 0; i < 4; i++) begin
      sb_merged[8*i +: 8] = (lane == 2'(i)) ? rf_rdata2[7:0] : mem_rdata[8*i +: 8];
    end
  end

  // Handshake: step requests enter when idle or as the previous one completes
  assign idle      = (state_q == ST_IDLE);
  assign can_emit  = !out_valid_q || !out_stall_i;
  assign fin       = can_emit &&
                     (((state_q == ST_EXEC) && !mem_access) || (state_q == ST_MEM));
  assign in_stall_o = !((idle || fin) &&
                        ((in_req_i.req_type == REQ_STEP) || (idle && can_emit)));
  assign in_acc    = in_valid_i && !in_stall_o;
  assign step_acc  = in_acc && (in_req_i.req_type == REQ_STEP);
  assign write_acc = in_acc && (in_req_i.req_type == REQ_WRITE);
  assign pc_d      = fin ? pc_next_x : pc_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (step_acc) state_d = ST_DECODE;
      ST_DECODE: state_d = ST_EXEC;
      ST_EXEC: begin
        if (mem_access) begin
          state_d = ST_MEM;
        end else if (fin) begin
          state_d = step_acc ? ST_DECODE : ST_IDLE;
        end
      end
      ST_MEM: if (fin) state_d = step_acc ? ST_DECODE : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory, register file and result controls
  always_comb begin
    wr_load   = write_acc;
    wr_sw     = fin && (state_q == ST_EXEC) && is_sw;
    wr_sb     = fin && (state_q == ST_MEM) && is_sb;
    mem_we    = wr_load || wr_sw || wr_sb;
    mem_waddr = wr_load ? AW'(in_req_i.load_addr) : widx_x;
    mem_wdata = wr_load ? in_req_i.load_data : (wr_sb ? sb_merged : rf_rdata2);
    mem_re    = step_acc || ((state_q == ST_EXEC) && mem_access);
    mem_raddr = step_acc ? pc_d[AW+1:2] : widx_x;
    rf_re     = (state_q == ST_DECODE);

    rsp_d = '0;
    rsp_d.pc_after = pc_d;
    if (state_q == ST_EXEC) begin
      rsp_d.reg_we     = alu_wr && rd_ok;
      rsp_d.reg_value  = (alu_wr && rd_ok) ? alu_val : '0;
      rsp_d.mem_we     = is_sw;
      rsp_d.mem_word   = is_sw ? MEM_WORD_W'(widx_x) : '0;
      rsp_d.bad_opcode = bad;
    end else if (state_q == ST_MEM) begin
      rsp_d.reg_we     = (is_lw || is_lbu) && rd_ok;
      rsp_d.reg_value  = ((is_lw || is_lbu) && rd_ok) ? ld_val : '0;
      rsp_d.mem_we     = is_sb;
      rsp_d.mem_word   = is_sb ? MEM_WORD_W'(widx_x) : '0;
    end
    rsp_d.reg_num = rsp_d.reg_we ? rd[REG_NUM_W-1:0] : '0;
    rf_we = fin && rsp_d.reg_we;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      if (fin || write_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the instruction and the result payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DECODE) begin
      inst_q <= mem_rdata;
    end
    if (fin || write_acc) begin
      out_rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // At most one memory writer per cycle
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({wr_load, wr_sw, wr_sb}))
    else $error("more than one memory write source");

  // Memory word writes only enter an empty core
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_acc |-> idle)
    else $error("word write taken while an instruction is in flight");

  // Decode always moves on to execute
  a_decode_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECODE) |=> (state_q == ST_EXEC))
    else $error("decode did not advance");

  // A completing request leaves a valid result
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin || write_acc) |=> out_valid_q)
    else $error("completed request left no result");

  // Register zero is never written
  a_no_x0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> (rd != '0))
    else $error("write to register zero");

endmodule
